[rtl/pdf_pkg.sv]
package pdf_pkg;

    localparam int CHAN_BITS      = 8;
    localparam int NUM_CHAN       = 3;
    localparam int NUM_NEIGHBOURS = 8;
    localparam int COORD_BITS     = 10;
    localparam int ALPHA_BITS     = 9;
    localparam int SIZE_BITS      = 11;
    localparam int CFG_INDEX_BITS = 2;
    localparam int MAX_RESULTS    = 3;
    localparam int COUNT_BITS     = 2;
    localparam int MIN_SIZE       = 3;
    localparam int MAX_HEIGHT     = 1024;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;

    localparam logic [ALPHA_BITS-1:0] ALPHA_MAX = ALPHA_BITS'(256);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ALPHA  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef logic [CHAN_BITS-1:0] chan_t;
    typedef chan_t [NUM_CHAN-1:0] pixel_t;

    typedef struct packed {
        pixel_t                pix;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic                  last_of_run;
        logic                  frame_done;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] slots;
        logic [COUNT_BITS-1:0]     count;
    } bundle_t;

    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic at_col_last;
        logic at_row_last;
    } pos_flags_t;

endpackage

[rtl/pdf_pixel_if.sv]
interface pdf_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [pdf_pkg::CHAN_BITS-1:0] red_in;
    logic [pdf_pkg::CHAN_BITS-1:0] green_in;
    logic [pdf_pkg::CHAN_BITS-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

[rtl/pdf_result_if.sv]
interface pdf_result_if;
    logic                           valid;
    logic                           ready;
    logic [pdf_pkg::CHAN_BITS-1:0]  red_out;
    logic [pdf_pkg::CHAN_BITS-1:0]  green_out;
    logic [pdf_pkg::CHAN_BITS-1:0]  blue_out;
    logic [pdf_pkg::COORD_BITS-1:0] out_col;
    logic [pdf_pkg::COORD_BITS-1:0] out_row;
    logic                           last_of_run;
    logic                           frame_done;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output out_col, output out_row, output last_of_run, output frame_done,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input out_col, input out_row, input last_of_run, input frame_done,
                    output ready);
endinterface

[rtl/pdf_line_store.sv]
module pdf_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output pdf_pkg::pixel_t          rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  pdf_pkg::pixel_t          wr_data
);
    import pdf_pkg::*;

    pixel_t mem [DEPTH];
    pixel_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/pdf_kernel.sv]
module pdf_kernel (
    input  logic [pdf_pkg::ALPHA_BITS-1:0]                alpha,
    input  pdf_pkg::pixel_t                               centre,
    input  pdf_pkg::pixel_t [pdf_pkg::NUM_NEIGHBOURS-1:0] neighbours,
    output pdf_pkg::pixel_t                               diffused
);
    import pdf_pkg::*;

    // The weighted sum is rewritten as 2048*centre + a*(sum - 8*centre), which
    // needs one multiplier per channel and is never negative.
    logic        [CHAN_BITS+2:0]  sum   [NUM_CHAN];
    logic signed [CHAN_BITS+4:0]  diff  [NUM_CHAN];
    logic signed [CHAN_BITS+15:0] total [NUM_CHAN];

    always_comb
    begin
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            sum[k] = '0;
            for (int n = 0; n < NUM_NEIGHBOURS; n++)
            begin
                sum[k] = sum[k] + (CHAN_BITS+3)'(neighbours[n][k]);
            end
            diff[k]  = signed'({2'b00, sum[k]}) - signed'({2'b00, centre[k], 3'b000});
            total[k] = signed'({5'b00000, centre[k], 11'b0})
                     + (CHAN_BITS+16)'(signed'({1'b0, alpha})) * (CHAN_BITS+16)'(diff[k]);
            diffused[k] = total[k][CHAN_BITS+10:11];
        end
    end

endmodule

[rtl/pdf_result_buffer.sv]
module pdf_result_buffer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  pdf_pkg::bundle_t bundle,
    output logic             free,
    pdf_result_if.source     result
);
    import pdf_pkg::*;

    result_t [MAX_RESULTS-1:0] slots_reg;
    logic [COUNT_BITS-1:0]     count_reg;
    logic [COUNT_BITS-1:0]     idx_reg;
    logic                      valid;
    logic                      fire;
    logic                      on_last;
    result_t                   cur;

    assign valid   = idx_reg < count_reg;
    assign fire    = valid && result.ready;
    assign on_last = COUNT_BITS'(idx_reg + 1'b1) == count_reg;
    assign free    = !valid || (fire && on_last);
    assign cur     = slots_reg[idx_reg];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slots_reg <= bundle.slots;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            count_reg <= bundle.count;
            idx_reg   <= '0;
        end
        else if (fire)
        begin
            if (on_last)
            begin
                count_reg <= '0;
                idx_reg   <= '0;
            end
            else
            begin
                idx_reg <= COUNT_BITS'(idx_reg + 1'b1);
            end
        end
    end

    assign result.valid       = valid;
    assign result.red_out     = cur.pix[0];
    assign result.green_out   = cur.pix[1];
    assign result.blue_out    = cur.pix[2];
    assign result.out_col     = cur.col;
    assign result.out_row     = cur.row;
    assign result.last_of_run = cur.last_of_run;
    assign result.frame_done  = cur.frame_done;

endmodule

[rtl/pixel_diffusion_3x3_filter.sv]
// Streaming 3x3 neighbour diffusion filter for RGB frames.
// Pixels arrive on the pixel channel in raster order, one transfer per pixel.
// Each interior pixel becomes, per channel, ((256-a)*8*centre + a*sum of its
// eight neighbours) >> 11, with a the alpha register; border pixels pass through.
// Results leave on the result channel with their column and row; one input
// pixel causes between zero and three result transfers, the last of which
// carries last_of_run, and the final pixel of a frame carries frame_done.
// A transferred pixel is registered with its two line store reads, and its
// results then go to the result buffer once it is free. While the receiver
// is ready the result port moves one transfer per clock, and the input side
// takes one pixel per clock while each pixel causes at most one result; a
// pixel causing two or three results holds the input back while they leave.
// When the receiver stalls, the pending results hold steady and the input
// stops once the work register is also full. Reset empties the pipeline,
// returns the position to the frame start and loads the register defaults;
// the line stores need no clearing pass. Writing the width or height restarts
// the frame; the user must make writes only while idle, unchecked by the block.
module pixel_diffusion_3x3_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    pdf_pixel_if.sink                          pixel,
    pdf_result_if.source                       result,
    input  logic                               write_enable,
    input  logic [pdf_pkg::CFG_INDEX_BITS-1:0] write_index,
    input  logic [pdf_pkg::SIZE_BITS-1:0]      write_data
);
    import pdf_pkg::*;

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int RST_WIDTH = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

    // Configuration, held already clamped: alpha limited to 256, and the frame
    // size kept as the index of the last column and of the last row.
    logic [ALPHA_BITS-1:0] alpha_reg;
    logic [COL_BITS-1:0]   col_last_reg;
    logic [COORD_BITS-1:0] row_last_reg;
    logic [ALPHA_BITS-1:0] alpha_next;
    logic [COL_BITS-1:0]   col_last_next;
    logic [COORD_BITS-1:0] row_last_next;

    // Position of the next input pixel.
    logic [COL_BITS-1:0]   col_reg;
    logic [COORD_BITS-1:0] row_reg;

    // Work register: one accepted pixel, waiting for its line store data.
    logic                  b_valid_reg;
    pixel_t                b_pix_reg;
    logic [COL_BITS-1:0]   b_col_reg;
    logic [COORD_BITS-1:0] b_row_reg;
    pos_flags_t            b_flags_reg;
    pos_flags_t            flags_next;

    // Window columns c-1 (0..2) and c-2 (3..5) of rows r-2, r-1 and r.
    pixel_t [5:0]          win_reg;

    pixel_t                top;
    pixel_t                mid;
    pixel_t                diffused;
    pixel_t [NUM_NEIGHBOURS-1:0] neighbours;
    bundle_t               bundle;
    logic                  buf_free;
    logic                  in_fire;
    logic                  b_fire;
    cfg_reg_t              cfg_sel;

    assign cfg_sel = cfg_reg_t'(write_index);
    assign b_fire  = b_valid_reg && buf_free;
    assign pixel.ready = !b_valid_reg || b_fire;
    assign in_fire = pixel.valid && pixel.ready;

    // Clamping of the written values happens once, at write time.
    always_comb
    begin
        alpha_next = (write_data[ALPHA_BITS-1:0] > ALPHA_MAX)
                   ? ALPHA_MAX : write_data[ALPHA_BITS-1:0];
        if (32'(write_data) < MIN_SIZE)
        begin
            col_last_next = COL_BITS'(MIN_SIZE - 1);
        end
        else if (32'(write_data) > MAX_WIDTH)
        begin
            col_last_next = COL_BITS'(MAX_WIDTH - 1);
        end
        else
        begin
            col_last_next = COL_BITS'(write_data - 1'b1);
        end
        if (32'(write_data) < MIN_SIZE)
        begin
            row_last_next = COORD_BITS'(MIN_SIZE - 1);
        end
        else if (32'(write_data) > MAX_HEIGHT)
        begin
            row_last_next = COORD_BITS'(MAX_HEIGHT - 1);
        end
        else
        begin
            row_last_next = COORD_BITS'(write_data - 1'b1);
        end
    end

    always_comb
    begin
        flags_next.row_ge1     = row_reg != '0;
        flags_next.row_ge2     = row_reg > COORD_BITS'(1);
        flags_next.col_ge1     = col_reg != '0;
        flags_next.col_ge2     = col_reg > COL_BITS'(1);
        flags_next.at_col_last = col_reg == col_last_reg;
        flags_next.at_row_last = row_reg == row_last_reg;
    end

    // Configuration registers and the position counters. A size write sends
    // the position back to the start of a frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg    <= '0;
            col_last_reg <= COL_BITS'(RST_WIDTH - 1);
            row_last_reg <= COORD_BITS'(RESET_HEIGHT - 1);
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else if (write_enable)
        begin
            unique case (cfg_sel)
                REG_ALPHA:
                begin
                    alpha_reg <= alpha_next;
                end
                REG_WIDTH:
                begin
                    col_last_reg <= col_last_next;
                    col_reg      <= '0;
                    row_reg      <= '0;
                end
                REG_HEIGHT:
                begin
                    row_last_reg <= row_last_next;
                    col_reg      <= '0;
                    row_reg      <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (in_fire)
        begin
            if (flags_next.at_col_last)
            begin
                col_reg <= '0;
                row_reg <= flags_next.at_row_last ? '0 : COORD_BITS'(row_reg + 1'b1);
            end
            else
            begin
                col_reg <= COL_BITS'(col_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (b_fire)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            b_pix_reg   <= {pixel.blue_in, pixel.green_in, pixel.red_in};
            b_col_reg   <= col_reg;
            b_row_reg   <= row_reg;
            b_flags_reg <= flags_next;
        end
    end

    // The window shifts one column each time a pixel is retired.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (b_fire)
        begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= top;
            win_reg[1] <= mid;
            win_reg[2] <= b_pix_reg;
        end
    end

    // Row r-1 is read at acceptance and rewritten with row r at retirement;
    // row r-2 likewise takes the old row r-1. The same column is read again
    // only a full row later, so the write has always landed by then.
    pdf_line_store #(.DEPTH(MAX_WIDTH)) u_store_prev (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (col_reg),
        .rd_data (mid),
        .wr_en   (b_fire),
        .wr_addr (b_col_reg),
        .wr_data (b_pix_reg)
    );

    pdf_line_store #(.DEPTH(MAX_WIDTH)) u_store_prev2 (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (col_reg),
        .rd_data (top),
        .wr_en   (b_fire),
        .wr_addr (b_col_reg),
        .wr_data (mid)
    );

    assign neighbours = {b_pix_reg, mid, top, win_reg[2], win_reg[0],
                         win_reg[5], win_reg[4], win_reg[3]};

    pdf_kernel u_kernel (
        .alpha      (alpha_reg),
        .centre     (win_reg[1]),
        .neighbours (neighbours),
        .diffused   (diffused)
    );

    // Pack the results of the retiring pixel in order: the pixel one row up
    // and one column left, then the right-hand border pixel of the row above
    // at the end of a row, then the pixel itself on the last row.
    always_comb
    begin
        logic [COUNT_BITS-1:0] n;
        n = '0;
        bundle = '0;
        if (b_flags_reg.row_ge1 && b_flags_reg.col_ge1)
        begin
            bundle.slots[n].pix = (b_flags_reg.row_ge2 && b_flags_reg.col_ge2)
                                ? diffused : win_reg[1];
            bundle.slots[n].col = COORD_BITS'(32'(COL_BITS'(b_col_reg - 1'b1)));
            bundle.slots[n].row = COORD_BITS'(b_row_reg - 1'b1);
            n = COUNT_BITS'(n + 1'b1);
        end
        if (b_flags_reg.row_ge1 && b_flags_reg.at_col_last)
        begin
            bundle.slots[n].pix = mid;
            bundle.slots[n].col = COORD_BITS'(32'(b_col_reg));
            bundle.slots[n].row = COORD_BITS'(b_row_reg - 1'b1);
            n = COUNT_BITS'(n + 1'b1);
        end
        if (b_flags_reg.at_row_last)
        begin
            bundle.slots[n].pix        = b_pix_reg;
            bundle.slots[n].col        = COORD_BITS'(32'(b_col_reg));
            bundle.slots[n].row        = b_row_reg;
            bundle.slots[n].frame_done = b_flags_reg.at_col_last;
            n = COUNT_BITS'(n + 1'b1);
        end
        if (n != '0)
        begin
            bundle.slots[COUNT_BITS'(n - 1'b1)].last_of_run = 1'b1;
        end
        bundle.count = n;
    end

    pdf_result_buffer u_result_buffer (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (b_fire),
        .bundle (bundle),
        .free   (buf_free),
        .result (result)
    );

endmodule

[rtl/pdf_checker.sv]
module pdf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [pdf_pkg::CHAN_BITS-1:0]  red_out,
    input logic [pdf_pkg::CHAN_BITS-1:0]  green_out,
    input logic [pdf_pkg::CHAN_BITS-1:0]  blue_out,
    input logic [pdf_pkg::COORD_BITS-1:0] out_col,
    input logic [pdf_pkg::COORD_BITS-1:0] out_row,
    input logic                           last_of_run,
    input logic                           frame_done
);
    import pdf_pkg::*;

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
            && $stable(blue_out) && $stable(out_col) && $stable(out_row)
            && $stable(last_of_run) && $stable(frame_done))
    else $error("stalled result changed");

    // The end of a frame is always the last result of its pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> last_of_run)
    else $error("frame_done without last_of_run");

    // The results of one pixel leave back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("gap inside the results of one pixel");

    // Nothing is offered while in reset.
    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
    else $error("result offered during reset");

endmodule

bind pixel_diffusion_3x3_filter pdf_checker u_pdf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .red_out     (result.red_out),
    .green_out   (result.green_out),
    .blue_out    (result.blue_out),
    .out_col     (result.out_col),
    .out_row     (result.out_row),
    .last_of_run (result.last_of_run),
    .frame_done  (result.frame_done)
);

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdf_pkg::*;

    // Depth of the line stores, which is also the widest frame the block takes.
    localparam int unsigned STORE_DEPTH     = 1024;
    // Shift that divides by the full weight of one pixel (256 * 8).
    localparam int unsigned WEIGHT_SHIFT    = $clog2(int'(ALPHA_MAX) * NUM_NEIGHBOURS);
    // Cycles allowed after the last expected result for the pipeline to empty.
    localparam int unsigned SETTLE_CYCLES   = 8;
    // Length of the long receiver hold-off used to fill the block up.
    localparam int unsigned HOLD_OFF_CYCLES = 150;
    // Bound on the final wait for outstanding results.
    localparam int unsigned END_WAIT_LIMIT  = 5000;
    // Pixels sent in the random part.
    localparam int unsigned RANDOM_ITEMS    = 150;
    // Pixels sent on the reset settings.
    localparam int unsigned DEFAULT_ITEMS   = 20;
    // Pixels sent on each of the extreme frame sizes.
    localparam int unsigned SIZE_RUN_ITEMS  = 12;
    // Cap on printed mismatch lines; all mismatches are still counted.
    localparam int unsigned MAX_PRINTED     = 60;

    typedef enum int unsigned {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      write_enable;
    logic [CFG_INDEX_BITS-1:0] write_index;
    logic [SIZE_BITS-1:0]      write_data;

    pdf_pixel_if  pixel ();
    pdf_result_if result ();

    pixel_diffusion_3x3_filter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pixel),
        .result       (result),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data)
    );

    // Predictor state: the register settings as written (clamping is applied at
    // use, whereas the block clamps at write time), the two line stores, the six
    // window registers holding columns c-1 and c-2 of the three rows, and the
    // raster position of the next pixel to arrive.
    logic [ALPHA_BITS-1:0] alpha_setting;
    logic [SIZE_BITS-1:0]  width_setting;
    logic [SIZE_BITS-1:0]  height_setting;
    pixel_t                prev_row  [STORE_DEPTH];
    pixel_t                prev2_row [STORE_DEPTH];
    pixel_t                col1_top, col1_mid, col1_bot;
    pixel_t                col2_top, col2_mid, col2_bot;
    int unsigned           next_col;
    int unsigned           next_row;

    // Diffused and passed-through pixels still owed by the block, oldest first.
    result_t               pending_results [$];

    int unsigned           error_count;

    // Sender burst control and the request for a long receiver hold-off.
    int unsigned           burst_left;
    bit                    sender_bursty;
    bit                    hold_request;

    always #5 clk = ~clk;

    function automatic int unsigned clamp_size(input int unsigned raw, input int unsigned upper);
        if (raw < MIN_SIZE)
            return MIN_SIZE;
        if (raw > upper)
            return upper;
        return raw;
    endfunction

    // Channel value biased towards the two extremes.
    function automatic chan_t random_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Works out the results caused by one accepted pixel and queues them, then
    // advances the window, the line stores and the raster position.
    task automatic predict_diffusion(input pixel_t bot);
        int unsigned w, h, a, r, c, n, k, sum, v;
        pixel_t      top, mid, res;
        result_t     outs [MAX_RESULTS];

        w = clamp_size(width_setting, STORE_DEPTH);
        h = clamp_size(height_setting, MAX_HEIGHT);
        a = (alpha_setting > ALPHA_MAX) ? int'(ALPHA_MAX) : alpha_setting;
        r = (next_row >= h) ? 0 : next_row;
        c = (next_col >= w) ? 0 : next_col;
        top = prev2_row[c];
        mid = prev_row[c];
        n = 0;

        // The centre pixel one row and one column behind; diffused only when it
        // has a full ring of neighbours, otherwise it lies on the top or left
        // border and passes through.
        if (r >= 1 && c >= 1) begin
            res = col1_mid;
            if (r >= 2 && c >= 2) begin
                for (k = 0; k < NUM_CHAN; k++) begin
                    sum = col2_top[k] + col2_mid[k] + col2_bot[k] + col1_top[k] + col1_bot[k]
                        + top[k] + mid[k] + bot[k];
                    v = ((int'(ALPHA_MAX) - a) * NUM_NEIGHBOURS * col1_mid[k] + a * sum)
                        >> WEIGHT_SHIFT;
                    res[k] = chan_t'(v);
                end
            end
            outs[n] = '{pix: res, col: COORD_BITS'(c - 1), row: COORD_BITS'(r - 1),
                        last_of_run: 1'b0, frame_done: 1'b0};
            n++;
        end
        // At the end of a row the right border pixel of the row above follows.
        if (r >= 1 && c == w - 1) begin
            outs[n] = '{pix: mid, col: COORD_BITS'(c), row: COORD_BITS'(r - 1),
                        last_of_run: 1'b0, frame_done: 1'b0};
            n++;
        end
        // Bottom row pixels are border pixels and leave as they arrive.
        if (r == h - 1) begin
            outs[n] = '{pix: bot, col: COORD_BITS'(c), row: COORD_BITS'(r),
                        last_of_run: 1'b0, frame_done: (c == w - 1)};
            n++;
        end
        if (n > 0)
            outs[n - 1].last_of_run = 1'b1;
        for (k = 0; k < n; k++)
            pending_results.push_back(outs[k]);

        col2_top = col1_top;
        col2_mid = col1_mid;
        col2_bot = col1_bot;
        col1_top = top;
        col1_mid = mid;
        col1_bot = bot;
        prev2_row[c] = mid;
        prev_row[c] = bot;

        if (c + 1 >= w) begin
            next_col = 0;
            next_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else begin
            next_col = c + 1;
            next_row = r;
        end
    endtask

    // Offers one pixel and returns at the edge where it is transferred. Valid is
    // left high so that back-to-back pixels follow without a gap; it only drops
    // for the gap between two bursts, or when the caller goes idle.
    task automatic send_pixel(input chan_t red, input chan_t green, input chan_t blue);
        pixel_t      pix;
        int unsigned gap;

        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = sender_bursty ? $urandom_range(1, 6) : 0;
        end
        burst_left--;
        if (gap > 0) begin
            pixel.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel.valid    <= 1'b1;
        pixel.red_in   <= red;
        pixel.green_in <= green;
        pixel.blue_in  <= blue;
        do
            @(posedge clk);
        while (pixel.ready !== 1'b1);
        pix[0] = red;
        pix[1] = green;
        pix[2] = blue;
        predict_diffusion(pix);
    endtask

    // Stops offering pixels and waits until every owed result has come back,
    // then waits out the settle time in case the last pixel is still in the
    // pipeline without having caused a result.
    task automatic wait_idle();
        pixel.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write. The enable is dropped again afterwards so that two
    // writes in a row never assign it twice in one time step.
    task automatic write_reg(input cfg_reg_t index, input logic [SIZE_BITS-1:0] data);
        write_enable <= 1'b1;
        write_index  <= index;
        write_data   <= data;
        @(posedge clk);
        case (index)
            REG_ALPHA:
                alpha_setting = data[ALPHA_BITS-1:0];
            REG_WIDTH:
            begin
                width_setting = data;
                next_col = 0;
                next_row = 0;
            end
            REG_HEIGHT:
            begin
                height_setting = data;
                next_col = 0;
                next_row = 0;
            end
            default:
                ;
        endcase
        write_enable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [COORD_BITS-1:0] got,
                                 input logic [COORD_BITS-1:0] want, input result_t slot);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h, for pixel at col %0d row %0d",
                                      name, got, want, slot.col, slot.row));
    endtask

    task automatic check_result();
        result_t want;

        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result at col %0d row %0d with nothing expected",
                                      result.out_col, result.out_row));
            return;
        end
        want = pending_results.pop_front();
        compare_field("red_out",     result.red_out,     want.pix[0],      want);
        compare_field("green_out",   result.green_out,   want.pix[1],      want);
        compare_field("blue_out",    result.blue_out,    want.pix[2],      want);
        compare_field("out_col",     result.out_col,     want.col,         want);
        compare_field("out_row",     result.out_row,     want.row,         want);
        compare_field("last_of_run", result.last_of_run, want.last_of_run, want);
        compare_field("frame_done",  result.frame_done,  want.frame_done,  want);
    endtask

    // Nothing is written before the first pixels, so the frame size comes from
    // the reset values. The first pixels all lie on row zero of a wide frame,
    // so none of them may cause a result.
    task automatic test_register_defaults();
        repeat (DEFAULT_ITEMS)
            send_pixel(random_level(), random_level(), random_level());
    endtask

    // Smallest frames with the extreme channel values. The first frame has the
    // full neighbour weight, so the centre becomes the mean of its ring; the
    // second frame follows without a size write, so the position must wrap at
    // the end of the first, and uses an alpha above range that is taken as 256.
    // Sizes below the minimum are written and must be taken as three.
    task automatic test_directed_extremes();
        wait_idle();
        write_reg(REG_WIDTH, SIZE_BITS'(2));
        write_reg(REG_HEIGHT, SIZE_BITS'(0));
        write_reg(REG_ALPHA, SIZE_BITS'(ALPHA_MAX));
        for (int i = 0; i < 9; i++)
            if (i == 4)
                send_pixel(8'h00, 8'hFF, 8'h00);
            else
                send_pixel(8'hFF, 8'h00, 8'hFF);
        wait_idle();
        write_reg(REG_ALPHA, '1);
        for (int i = 0; i < 9; i++)
            if (i == 4)
                send_pixel(8'hFF, 8'h00, 8'hFF);
            else
                send_pixel(8'h00, 8'hFF, 8'h00);
    endtask

    // An alpha change part way through a frame takes effect from the next
    // pixel, whereas a size change part way through restarts the frame.
    task automatic test_mid_frame_writes();
        wait_idle();
        write_reg(REG_WIDTH, SIZE_BITS'(4));
        write_reg(REG_HEIGHT, SIZE_BITS'(3));
        write_reg(REG_ALPHA, SIZE_BITS'(64));
        repeat (6) send_pixel(random_level(), random_level(), random_level());
        wait_idle();
        write_reg(REG_ALPHA, SIZE_BITS'(200));
        repeat (11) send_pixel(random_level(), random_level(), random_level());
        wait_idle();
        write_reg(REG_WIDTH, SIZE_BITS'(3));
        repeat (9) send_pixel(random_level(), random_level(), random_level());
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // pixels without gaps, so the block fills up and must stall its input
    // without losing or repeating anything.
    task automatic test_back_pressure();
        wait_idle();
        write_reg(REG_WIDTH, SIZE_BITS'(5));
        write_reg(REG_HEIGHT, SIZE_BITS'(4));
        write_reg(REG_ALPHA, SIZE_BITS'(100));
        sender_bursty = 1'b0;
        hold_request = 1'b1;
        repeat (40) send_pixel(random_level(), random_level(), random_level());
        sender_bursty = 1'b1;
    endtask

    // Mostly whole frames of small random sizes, with alpha drawn from the whole
    // of its range; out of range values of both are among them. Some
    // runs stop part way through a frame, so the next settings land mid-frame.
    task automatic test_random_frames();
        int unsigned sent, count, w, h;

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            sender_bursty = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0:       write_reg(REG_ALPHA, '0);
                1:       write_reg(REG_ALPHA, SIZE_BITS'(ALPHA_MAX));
                2:       write_reg(REG_ALPHA, SIZE_BITS'($urandom_range(257, 2047)));
                default: write_reg(REG_ALPHA, SIZE_BITS'($urandom_range(1, 255)));
            endcase
            if ($urandom_range(0, 3) != 0)
                case ($urandom_range(0, 9))
                    0:       write_reg(REG_WIDTH, SIZE_BITS'($urandom_range(0, 2)));
                    1:       write_reg(REG_WIDTH, SIZE_BITS'($urandom_range(11, 24)));
                    default: write_reg(REG_WIDTH, SIZE_BITS'($urandom_range(3, 8)));
                endcase
            if ($urandom_range(0, 3) != 0)
                case ($urandom_range(0, 9))
                    0:       write_reg(REG_HEIGHT, SIZE_BITS'($urandom_range(0, 2)));
                    default: write_reg(REG_HEIGHT, SIZE_BITS'($urandom_range(3, 5)));
                endcase
            w = clamp_size(width_setting, STORE_DEPTH);
            h = clamp_size(height_setting, MAX_HEIGHT);
            if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, w * h);
            else
                count = w * h * $urandom_range(1, 2);
            if (count > RANDOM_ITEMS - sent)
                count = RANDOM_ITEMS - sent;
            repeat (count) send_pixel(random_level(), random_level(), random_level());
            sent += count;
        end
    endtask

    // The widest setting, written above range so that it is clamped, must keep
    // a short run of pixels on row zero, where none of them causes a result.
    // The tallest setting, on the narrowest width, must keep the rows counting
    // on past the point where a small frame would already have wrapped.
    task automatic test_size_limits();
        wait_idle();
        write_reg(REG_ALPHA, SIZE_BITS'($urandom_range(0, 256)));
        write_reg(REG_WIDTH, '1);
        write_reg(REG_HEIGHT, SIZE_BITS'(MIN_SIZE));
        repeat (SIZE_RUN_ITEMS)
            send_pixel(random_level(), random_level(), random_level());
        wait_idle();
        write_reg(REG_WIDTH, '0);
        write_reg(REG_HEIGHT, '1);
        repeat (SIZE_RUN_ITEMS)
            send_pixel(random_level(), random_level(), random_level());
    endtask

    // Every result transfer is checked against the oldest owed pixel. The
    // handshake is sampled at the clock edge, before any of this edge's updates.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result.valid === 1'b1 && result.ready === 1'b1)
                check_result();
        end
    end

    // Receiver: runs through stretches of always ready, random stalls and a
    // fixed stall pattern, with a long hold-off whenever a test asks for one.
    initial
    begin
        rx_mode_t    mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned phase;

        mode = RX_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        phase = 0;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (mode_left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else begin
                case (mode)
                    RX_RANDOM:  result.ready <= ($urandom_range(0, 2) != 0);
                    RX_PATTERN: result.ready <= ((phase % 5) >= 2);
                    default:    result.ready <= 1'b1;
                endcase
            end
        end
    end

    // Generous guard against a hung handshake.
    initial
    begin
        #10_000_000;
        $display("FAIL pixel_diffusion_3x3_filter");
        $finish;
    end

    initial
    begin
        rst_n          <= 1'b0;
        write_enable   <= 1'b0;
        write_index    <= REG_ALPHA;
        write_data     <= '0;
        pixel.valid    <= 1'b0;
        pixel.red_in   <= '0;
        pixel.green_in <= '0;
        pixel.blue_in  <= '0;

        // Predictor starts from the same state as the block after reset.
        alpha_setting  = '0;
        width_setting  = SIZE_BITS'(RESET_WIDTH);
        height_setting = SIZE_BITS'(RESET_HEIGHT);
        foreach (prev_row[i])
        begin
            prev_row[i]  = '0;
            prev2_row[i] = '0;
        end
        col1_top = '0;
        col1_mid = '0;
        col1_bot = '0;
        col2_top = '0;
        col2_mid = '0;
        col2_bot = '0;
        next_col = 0;
        next_row = 0;
        error_count   = 0;
        burst_left    = 0;
        sender_bursty = 1'b1;
        hold_request  = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_directed_extremes();
        test_mid_frame_writes();
        test_back_pressure();
        test_random_frames();
        test_size_limits();

        // Let the last results drain, within a bound, and give the pipeline
        // time to show anything that was never asked for.
        pixel.valid <= 1'b0;
        for (int i = 0; i < END_WAIT_LIMIT && pending_results.size() != 0; i++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));

        if (error_count == 0)
            $display("PASS pixel_diffusion_3x3_filter");
        else
            $display("FAIL pixel_diffusion_3x3_filter");
        $finish;
    end

endmodule
